// ===== design/hamdc_pkg.sv =====
`default_nettype none

package hamdc_pkg;

  // Volume divisor and the leak ratio of the DC tracker
  localparam int VOLUME_MAX = 100;
  localparam int LEAK_DEN   = 100;     // leak is A * (LEAK_DEN - 1) / LEAK_DEN

  // Reciprocal divider: q ~ (m * floor(2^DIV_SHIFT / d)) >> DIV_SHIFT, then one fix-up
  localparam int DIV_SHIFT = 32;
  localparam int DIV_W     = 16;       // divisor width
  localparam int RECIP_W   = 33;       // reciprocal width (holds 2^32 for a divisor of one)

  localparam logic [RECIP_W-1:0] K_VOL  = RECIP_W'((64'd1 << DIV_SHIFT) / 64'(VOLUME_MAX));
  localparam logic [RECIP_W-1:0] K_LEAK = RECIP_W'((64'd1 << DIV_SHIFT) / 64'(LEAK_DEN));

  // Mixer limits (10-bit signed)
  localparam int MIX_MIN = -512;
  localparam int MIX_MAX = 511;

  // Integrator gain: times 20, then floor divide by 2^15
  localparam int DC_SHIFT = 15;

  // Configuration register indexes
  localparam logic [1:0] REG_PSG_SEL = 2'd0;
  localparam logic [1:0] REG_A_FULL  = 2'd1;
  localparam logic [1:0] REG_B_FULL  = 2'd2;
  localparam logic [1:0] REG_VOLUME  = 2'd3;

  localparam logic [6:0] VOLUME_RESET = 7'd100;

  // Sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX,
    ST_DV1,
    ST_DV2,
    ST_VOL,
    ST_LK1,
    ST_LK2,
    ST_DC,
    ST_ACC
  } step_t;

  // Command from the controller to both lanes
  typedef struct packed {
    logic  load;
    step_t step;
    logic  commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/hamdc_ctrl.sv =====
`default_nettype none

module hamdc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          out_free,
  output logic               in_tready,
  output hamdc_pkg::cmd_t    cmd
);
  import hamdc_pkg::*;

  step_t step_r, step_nxt;

  // Hold the current step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Sequence the eight datapath steps; overlap the next accept with the commit
  always_comb begin
    step_nxt   = step_r;
    in_tready  = 1'b0;
    cmd.step   = step_r;
    cmd.commit = 1'b0;
    cmd.load   = 1'b0;
    case (step_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          step_nxt = ST_MIX;
        end
      end
      ST_MIX: step_nxt = ST_DV1;
      ST_DV1: step_nxt = ST_DV2;
      ST_DV2: step_nxt = ST_VOL;
      ST_VOL: step_nxt = ST_LK1;
      ST_LK1: step_nxt = ST_LK2;
      ST_LK2: step_nxt = ST_DC;
      ST_DC:  step_nxt = ST_ACC;
      ST_ACC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          in_tready  = 1'b1;
          step_nxt   = in_tvalid ? ST_MIX : ST_IDLE;
        end
      end
      default: step_nxt = ST_IDLE;
    endcase
    cmd.load = in_tready & in_tvalid;
  end

endmodule

`default_nettype wire

// ===== design/hamdc_lane.sv =====
`default_nettype none

module hamdc_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hamdc_pkg::cmd_t    cmd,
  input  wire logic signed [15:0] ds_sample,
  input  wire logic signed [15:0] psg_sample,
  input  wire logic               ds_full,
  input  wire logic        [1:0]  psg_sel,
  input  wire logic        [6:0]  volume,
  output logic signed      [15:0] result
);
  import hamdc_pkg::*;

  // Captured frame samples
  logic signed [15:0] ds_r, psg_r;

  // Working registers
  logic               neg_r;       // sign of the value under division
  logic               leak_sel_r;  // divider works on the leak (else volume)
  logic        [31:0] div_m_r;     // magnitude being divided
  logic        [31:0] q0_r;        // quotient estimate
  logic        [31:0] q_r;         // exact quotient
  logic               rnz_r;       // remainder nonzero
  logic signed [15:0] x_r;         // volume-scaled sample
  logic signed [24:0] d_r;         // integrator increment
  logic signed [31:0] acc_r;       // DC accumulator, Q16.16

  // Mix: scale and clip direct sound, shift tone, clip sum, apply volume
  logic signed [17:0] ds_scl;
  logic signed [9:0]  d_clip;
  logic signed [15:0] tone;
  logic signed [16:0] mix_sum;
  logic signed [9:0]  mix_clip;
  logic signed [15:0] mix_scl;
  logic signed [7:0]  vol_s;
  logic signed [23:0] prod;
  logic        [23:0] prod_mag;

  always_comb begin
    ds_scl = ds_full ? {ds_r, 2'b00} : {ds_r[15], ds_r, 1'b0};
    if (ds_scl < MIX_MIN) begin
      d_clip = 10'(MIX_MIN);
    end else if (ds_scl > MIX_MAX) begin
      d_clip = 10'(MIX_MAX);
    end else begin
      d_clip = ds_scl[9:0];
    end
    // Select one acts as a half, two as full level, zero and three as a quarter
    case (psg_sel)
      2'd1:    tone = psg_r >>> 1;
      2'd2:    tone = psg_r;
      default: tone = psg_r >>> 2;
    endcase
    mix_sum = {{7{d_clip[9]}}, d_clip} + {tone[15], tone};
    if (mix_sum < MIX_MIN) begin
      mix_clip = 10'(MIX_MIN);
    end else if (mix_sum > MIX_MAX) begin
      mix_clip = 10'(MIX_MAX);
    end else begin
      mix_clip = mix_sum[9:0];
    end
    mix_scl  = {mix_clip, 6'b000000};
    vol_s    = {1'b0, volume};
    prod     = mix_scl * vol_s;
    prod_mag = prod[23] ? 24'(-prod) : prod;
  end

  // Shared constant divider: reciprocal multiply, then one correction
  logic [DIV_W-1:0]   d_sel;
  logic [RECIP_W-1:0] k_sel;
  logic [64:0]        recip_prod;
  logic [47:0]        qd;
  logic [47:0]        rem;
  logic               rem_ge;

  always_comb begin
    d_sel      = leak_sel_r ? DIV_W'(LEAK_DEN) : DIV_W'(VOLUME_MAX);
    k_sel      = leak_sel_r ? K_LEAK : K_VOL;
    recip_prod = 65'(div_m_r) * 65'(k_sel);
    qd         = 48'(q0_r) * 48'(d_sel);
    rem        = 48'(div_m_r) - qd;
    rem_ge     = rem >= 48'(d_sel);
  end

  // Volume result: apply sign, saturate to 16 bits
  logic signed [15:0] x_sat;

  always_comb begin
    if (!neg_r) begin
      x_sat = (q_r > 32'd32767) ? 16'sh7FFF : q_r[15:0];
    end else begin
      x_sat = (q_r > 32'd32768) ? 16'sh8000 : 16'(16'd0 - q_r[15:0]);
    end
  end

  // Leak and increment: leak = A + floor(-A / 100), d = floor((X - leak) * 20 / 2^15)
  logic signed [33:0] fl;
  logic signed [33:0] leak;
  logic signed [34:0] diff;
  logic signed [39:0] diff_w;
  logic signed [39:0] times20;

  always_comb begin
    fl      = neg_r ? -($signed({2'b00, q_r}) + $signed({33'd0, rnz_r}))
                    : $signed({2'b00, q_r});
    leak    = {{2{acc_r[31]}}, acc_r} + fl;
    diff    = {{3{x_r[15]}}, x_r, 16'd0} - {leak[33], leak};
    diff_w  = {{5{diff[34]}}, diff};
    times20 = (diff_w <<< 4) + (diff_w <<< 2);
  end

  // Accumulate with saturation, subtract the DC estimate from the sample
  logic signed [33:0] asum;
  logic signed [31:0] acc_new;
  logic signed [16:0] osum;

  always_comb begin
    asum = {{2{acc_r[31]}}, acc_r} + {{9{d_r[24]}}, d_r};
    if (asum > 34'sh0_7FFF_FFFF) begin
      acc_new = 32'sh7FFF_FFFF;
    end else if (asum < -34'sh0_8000_0000) begin
      acc_new = 32'sh8000_0000;
    end else begin
      acc_new = asum[31:0];
    end
    osum = {x_r[15], x_r} - {acc_new[31], acc_new[31:16]};
    if (osum > 17'sd32767) begin
      result = 16'sh7FFF;
    end else if (osum < -17'sd32768) begin
      result = 16'sh8000;
    end else begin
      result = osum[15:0];
    end
  end

  // Capture samples on an accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ds_r  <= ds_sample;
      psg_r <= psg_sample;
    end
  end

  // Advance the datapath one step per cycle, except while the sequencer idles or waits at its last step
  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_MIX: begin
        neg_r      <= prod[23];
        div_m_r    <= {8'd0, prod_mag};
        leak_sel_r <= 1'b0;
      end
      ST_DV1, ST_LK1: begin
        q0_r <= recip_prod[63:32];
      end
      ST_DV2, ST_LK2: begin
        q_r   <= q0_r + 32'(rem_ge);
        rnz_r <= rem_ge ? (rem != 48'(d_sel)) : (rem != 48'd0);
      end
      ST_VOL: begin
        x_r        <= x_sat;
        // Divide -A: negative when A is positive
        neg_r      <= !acc_r[31] && (acc_r != 32'sd0);
        div_m_r    <= acc_r[31] ? 32'(-acc_r) : acc_r;
        leak_sel_r <= 1'b1;
      end
      ST_DC: begin
        d_r <= times20[39:DC_SHIFT];
      end
      default: begin
      end
    endcase
  end

  // Update the accumulator once per frame, when the result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'sd0;
    end else if (cmd.commit) begin
      acc_r <= acc_new;
    end
  end

endmodule

`default_nettype wire

// ===== design/handheld_audio_mixer_dc_block.sv =====
// Stereo mixer with DC blocker.
// Input channel (in_*): one stereo frame per transaction, four signed 16-bit
// samples in in_tdata. Output channel (out_*): one transaction per frame with
// the left and right signed 16-bit results in out_tdata.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// 0 tone level select, 1 direct sound A full, 2 direct sound B full,
// 3 speaker volume. Write only while no frame is in flight.
// Each frame runs through the eight-step sequence in each lane, whose
// constant divider (reciprocal multiply plus correction) is used twice per
// frame: once for volume, once for the integrator leak. A new frame is not
// taken while one is still before its last step; it is taken in the same
// cycle a result enters the output register.
// Reset clears the sequencer, output valid, the DC accumulators and the
// configuration (volume resets to 100). When the receiver stalls, the result
// holds in the output register; the next frame may already be taken and runs
// up to its last step, then waits until the output register frees.
`default_nettype none

module handheld_audio_mixer_dc_block (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // dsound_a_sample, dsound_b_sample, psg_left, psg_right
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // out_left, out_right
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  import hamdc_pkg::*;

  // Configuration registers
  logic [1:0] psg_sel_r;
  logic       a_full_r, b_full_r;
  logic [6:0] volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psg_sel_r <= 2'd0;
      a_full_r  <= 1'b0;
      b_full_r  <= 1'b0;
      volume_r  <= VOLUME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PSG_SEL: psg_sel_r <= cfg_wdata[1:0];
        REG_A_FULL:  a_full_r  <= cfg_wdata[0];
        REG_B_FULL:  b_full_r  <= cfg_wdata[0];
        REG_VOLUME:  volume_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Controller
  cmd_t cmd;
  logic out_tvalid_r;
  logic out_free;

  assign out_free = !out_tvalid_r || out_tready;

  hamdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Lanes: direct sound B feeds the left, A feeds the right
  logic signed [15:0] left_res, right_res;

  hamdc_lane u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .ds_sample  (in_tdata[31:16]),
    .psg_sample (in_tdata[47:32]),
    .ds_full    (b_full_r),
    .psg_sel    (psg_sel_r),
    .volume     (volume_r),
    .result     (left_res)
  );

  hamdc_lane u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .ds_sample  (in_tdata[15:0]),
    .psg_sample (in_tdata[63:48]),
    .ds_full    (a_full_r),
    .psg_sel    (psg_sel_r),
    .volume     (volume_r),
    .result     (right_res)
  );

  // Output register
  logic [31:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= {right_res, left_res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A committed result is presented next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid_r)
    else $error("committed result not presented");

  // An accepted frame always starts at the mix step
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (cmd.step == ST_MIX))
    else $error("accepted frame did not start");

  // The last step waits only on a full, stalled output register
  a_acc_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.step == ST_ACC) && !cmd.commit) |-> (out_tvalid_r && !out_tready))
    else $error("last step stalled without cause");

  // Never commit over a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && out_tvalid_r) |-> out_tready)
    else $error("result overwritten");

endmodule

`default_nettype wire

// ===== sim/handheld_audio_mixer_dc_block_checker.sv =====
`default_nettype none

// Watch the three ports, predict every stereo frame and compare results in order.
module handheld_audio_mixer_dc_block_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,   // dsound_a_sample, dsound_b_sample, psg_left, psg_right
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // out_left, out_right
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  output int               fail_count,
  output int               pending
);
  import hamdc_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  // Frames accepted at the input whose results have not come out yet
  stereo_t stereo_due[$];

  // Register copies and DC tracker state
  logic [1:0] tone_sel;
  logic       a_full;
  logic       b_full;
  logic [6:0] volume;
  longint     acc_left;
  longint     acc_right;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // Direct sound plus tone for one side, clamped, scaled to 16 bits and by volume
  function automatic longint side_level(logic signed [15:0] ds, logic full,
                                        logic signed [15:0] tone);
    longint d;
    longint t;
    longint s;
    int     sh;
    d  = clip(longint'(ds) * (full ? 4 : 2), MIX_MIN, MIX_MAX);
    sh = 2 - (int'(tone_sel) % 3);
    t  = longint'(tone) >>> sh;
    s  = clip(d + t, MIX_MIN, MIX_MAX) * 64;
    s  = (s * longint'(volume)) / VOLUME_MAX;
    return clip(s, -32768, 32767);
  endfunction

  // Leaky integrator step in Q16.16, saturating to 32 bits
  function automatic longint dc_track(longint x, longint acc);
    longint leak;
    longint d;
    leak = floor_quot(acc * 99, 100);
    d    = ((x * 65536 - leak) * 20) >>> 15;
    return clip(acc + d, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic stereo_t predict_frame(logic [63:0] d);
    stereo_t r;
    longint  lx;
    longint  rx;
    lx = side_level(d[31:16], b_full, d[47:32]);
    rx = side_level(d[15:0], a_full, d[63:48]);
    acc_left  = dc_track(lx, acc_left);
    acc_right = dc_track(rx, acc_right);
    r.left  = 16'(clip(lx - (acc_left >>> 16), -32768, 32767));
    r.right = 16'(clip(rx - (acc_right >>> 16), -32768, 32767));
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    stereo_t want;
    if (!rst_n) begin
      stereo_due.delete();
      tone_sel   = 2'd0;
      a_full     = 1'b0;
      b_full     = 1'b0;
      volume     = VOLUME_RESET;
      acc_left   = 0;
      acc_right  = 0;
      fail_count = 0;
    end else begin
      // Retire the oldest frame on each result transaction
      if (out_tvalid && out_tready) begin
        if (stereo_due.size() == 0) begin
          report_mismatch($sformatf("result 0x%08h arrived with no frame pending",
                                    out_tdata));
        end else begin
          want = stereo_due.pop_front();
          if (out_tdata[15:0] !== want.left)
            report_mismatch($sformatf("left: got %0d, expected %0d",
                                      $signed(out_tdata[15:0]), want.left));
          if (out_tdata[31:16] !== want.right)
            report_mismatch($sformatf("right: got %0d, expected %0d",
                                      $signed(out_tdata[31:16]), want.right));
        end
      end
      // Predict each accepted frame
      if (in_tvalid && in_tready) stereo_due.push_back(predict_frame(in_tdata));
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PSG_SEL: tone_sel = cfg_wdata[1:0];
          REG_A_FULL:  a_full   = cfg_wdata[0];
          REG_B_FULL:  b_full   = cfg_wdata[0];
          REG_VOLUME:  volume   = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = stereo_due.size();
  end

endmodule

`default_nettype wire

// ===== sim/handheld_audio_mixer_dc_block_tb.sv =====
`default_nettype none

module handheld_audio_mixer_dc_block_tb;
  import hamdc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // dsound_a_sample, dsound_b_sample, psg_left, psg_right
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_left, out_right
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int frames_sent;
  int settings_used;

  handheld_audio_mixer_dc_block dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  handheld_audio_mixer_dc_block_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the whole run
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [63:0] frame(logic [15:0] dsa, logic [15:0] dsb,
                                        logic [15:0] pl, logic [15:0] pr);
    return {pr, pl, dsb, dsa};
  endfunction

  // Mix of full-range values, values around the 10-bit clamp, and extremes
  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(1023)) - 16'd512;
      2: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom_range(600)) - 16'd300;
    endcase
    return v;
  endfunction

  // Offer one frame, idling first at random, and hold it until taken
  task automatic push_frame(logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    frames_sent++;
  endtask

  // Stop offering and wait until every result is out and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [1:0] sel, logic af, logic bf, logic [6:0] vol);
    settle();
    write_reg(REG_PSG_SEL, {5'd0, sel});
    write_reg(REG_A_FULL, {6'd0, af});
    write_reg(REG_B_FULL, {6'd0, bf});
    write_reg(REG_VOLUME, vol);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [6:0] vol;
    int         leftover;
    int         guard;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_PSG_SEL;
    cfg_wdata     = '0;
    hold_cycles   = 0;
    frames_sent   = 0;
    settings_used = 1;
    send_idle_pct = 32;
    recv_idle_pct = 64;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: extremes, clamp edges and floor of negative tones
    push_frame(frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    push_frame(frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    push_frame(frame(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    push_frame(frame(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
    push_frame(frame(16'h00FF, 16'h0100, 16'hFFFF, 16'hFFFD));
    push_frame(frame(16'hFF00, 16'hFEFF, 16'h0003, 16'h0001));
    push_frame(frame(16'h0001, 16'hFFFF, 16'h0800, 16'hF800));
    push_frame(frame(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));

    // Select three acts as a quarter; volume above maximum saturates
    apply_settings(2'd3, 1'b1, 1'b0, 7'd127);
    push_frame(frame(16'h007F, 16'h0080, 16'h0004, 16'hFFFC));
    push_frame(frame(16'h0080, 16'hFF7F, 16'h0000, 16'h0000));
    push_frame(frame(16'hFF80, 16'hFF7F, 16'hFFFB, 16'h0005));
    push_frame(frame(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000));
    push_frame(frame(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    push_frame(frame(16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0));

    // Volume zero mutes the mix, direct sound B at full level
    apply_settings(2'd1, 1'b0, 1'b1, 7'd0);
    push_frame(frame(16'h1234, 16'hFEDC, 16'h7FFF, 16'h8000));
    push_frame(frame(16'h0040, 16'hFFC0, 16'h0003, 16'hFFFD));
    push_frame(frame(16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
    push_frame(frame(16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Volume one: scaling truncates toward zero for negative sums
    apply_settings(2'd2, 1'b1, 1'b1, 7'd1);
    push_frame(frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_frame(frame(16'h0001, 16'h0001, 16'h0001, 16'h0001));
    push_frame(frame(16'hFFF9, 16'h0007, 16'h0013, 16'hFFED));
    push_frame(frame(16'h8000, 16'h7FFF, 16'h0100, 16'hFF00));

    // Hold full positive drive so the DC accumulators climb steadily
    apply_settings(2'd2, 1'b1, 1'b1, 7'd127);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (64) push_frame(frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));

    // Random frames under three idling patterns and several settings each
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 64 : 0);
      recv_idle_pct = (phase == 0) ? 64 : ((phase == 1) ? 32 : 0);
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(5))
          0: vol = 7'd0;
          1: vol = 7'd100;
          2: vol = 7'd127;
          3: vol = 7'd1;
          default: vol = 7'($urandom_range(127));
        endcase
        apply_settings(2'($urandom_range(3)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), vol);
        for (int n = 0; n < 64; n++) begin
          // Hold off the receiver so the block fills up and stalls its input
          if (k == 0 && n == 20) hold_cycles = 300;
          push_frame(frame(rand_sample(), rand_sample(), rand_sample(), rand_sample()));
        end
      end
    end

    // Drain remaining results
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (16) @(negedge clk);
    leftover = pending;
    if (leftover != 0) $display("%0d expected results never arrived", leftover);

    $display("Covered %0d frames over %0d register settings, with both idling ratios and none.",
             frames_sent, settings_used);
    $display("Included long output hold-offs and a full-scale run driving the DC trackers up.");
    if (fail_count == 0 && leftover == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
